FILE: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker modules
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sha1md_pkg.sv
// ------------------------------------------------------------------------
// sha1md_pkg
// types, constants and round functions of the sha-1 digest core
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1md_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	// chaining values after reset and after each digest
	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BYTE_LAST  = 6'd63;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] ROUND_SCHED = 7'd16;
	localparam logic [2:0] WORD_LAST  = 3'd4;

	// round constant by quarter
	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20)
			k = 32'h5A827999;
		else if (rnd < 7'd40)
			k = 32'h6ED9EBA1;
		else if (rnd < 7'd60)
			k = 32'h8F1BBCDC;
		else
			k = 32'hCA62C1D6;
		return k;
	endfunction

	// choose, parity or majority by quarter
	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20)
			f = (b & c) | (~b & d);
		else if (rnd < 7'd40 || rnd >= 7'd60)
			f = b ^ c ^ d;
		else
			f = (b & c) | (b & d) | (c & d);
		return f;
	endfunction

endpackage

FILE: rtl/sha1_message_digest_core.sv
// ------------------------------------------------------------------------
// sha1_message_digest_core
// streaming sha-1: bytes in, five big-endian digest words out
// ------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | data_byte, data_present, end_of_message
//  output  | out       | out_valid/out_stall| digest_word, last_word
//
//  an item that neither completes a block nor ends a message leaves the input
//  open for the next item. a byte that completes a block starts a compression:
//  the block load, one round a cycle on the single round unit, the chaining add.
//  an end item also writes the padding one byte a cycle outside compressions
//  (up to 72 bytes with one or two compressions), then shows five words; in_stall
//  stays high till the fifth word is taken. out_stall only holds the current word.
//  reset restores the initial chaining values and clears all counters.
`timescale 1ns / 1ps

module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        data_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        last_word
);

	sha1md_pkg::state_t state_q, state_d, resume_q, resume_d;

	logic [31:0] chain_q [5];
	logic [31:0] blk_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  round_q;
	logic [5:0]  bib_q;
	logic [60:0] count_q;
	logic [2:0]  word_q;

	logic        put_en;
	logic [7:0]  put_val;
	logic        count_en;
	logic        load_round;
	logic        round_run;
	logic        add_en;
	logic        emit_done;
	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	logic [31:0] w_cur;
	logic [31:0] t_sum;

	// length field bytes, most significant first
	assign len_bits = {count_q, 3'b000};
	assign len_byte = len_bits[{~bib_q[2:0], 3'b000} +: 8];

	// message schedule from fixed taps of the block window
	assign w_cur = (round_q < sha1md_pkg::ROUND_SCHED) ? blk_q[0] :
		{blk_q[13][30:0] ^ blk_q[8][30:0] ^ blk_q[2][30:0] ^ blk_q[0][30:0],
		 blk_q[13][31] ^ blk_q[8][31] ^ blk_q[2][31] ^ blk_q[0][31]};

	// shared round adder
	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1md_pkg::round_f(round_q, b_q, c_q, d_q)
		+ e_q + sha1md_pkg::round_k(round_q) + w_cur;

	// output word
	assign digest_word = chain_q[word_q];
	assign last_word   = (word_q == sha1md_pkg::WORD_LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1md_pkg::ST_IDLE;
			resume_q <= sha1md_pkg::ST_IDLE;
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;
		end
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		resume_d   = resume_q;
		put_en     = 1'b0;
		put_val    = '0;
		count_en   = 1'b0;
		load_round = 1'b0;
		round_run  = 1'b0;
		add_en     = 1'b0;
		emit_done  = 1'b0;
		in_stall   = 1'b1;
		out_valid  = 1'b0;
		unique case (state_q)
			sha1md_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (data_present) begin
						put_en   = 1'b1;
						put_val  = data_byte;
						count_en = 1'b1;
					end
					if (data_present && bib_q == sha1md_pkg::BYTE_LAST) begin
						state_d    = sha1md_pkg::ST_ROUND;
						load_round = 1'b1;
						resume_d   = end_of_message ? sha1md_pkg::ST_PAD80
							: sha1md_pkg::ST_IDLE;
					end else if (end_of_message) begin
						state_d = sha1md_pkg::ST_PAD80;
					end
				end
			end
			sha1md_pkg::ST_PAD80: begin
				put_en  = 1'b1;
				put_val = sha1md_pkg::PAD_BYTE;
				if (bib_q == sha1md_pkg::BYTE_LAST) begin
					state_d    = sha1md_pkg::ST_ROUND;
					load_round = 1'b1;
					resume_d   = sha1md_pkg::ST_ZERO;
				end else begin
					state_d = sha1md_pkg::ST_ZERO;
				end
			end
			sha1md_pkg::ST_ZERO: begin
				if (bib_q == sha1md_pkg::LEN_POS) begin
					state_d = sha1md_pkg::ST_LEN;
				end else begin
					put_en = 1'b1;
					// zero fill runs past the block end: compress and carry on
					if (bib_q == sha1md_pkg::BYTE_LAST) begin
						state_d    = sha1md_pkg::ST_ROUND;
						load_round = 1'b1;
						resume_d   = sha1md_pkg::ST_ZERO;
					end
				end
			end
			sha1md_pkg::ST_LEN: begin
				put_en  = 1'b1;
				put_val = len_byte;
				if (bib_q == sha1md_pkg::BYTE_LAST) begin
					state_d    = sha1md_pkg::ST_ROUND;
					load_round = 1'b1;
					resume_d   = sha1md_pkg::ST_EMIT;
				end
			end
			sha1md_pkg::ST_ROUND: begin
				round_run = 1'b1;
				if (round_q == sha1md_pkg::ROUND_LAST)
					state_d = sha1md_pkg::ST_ADD;
			end
			sha1md_pkg::ST_ADD: begin
				add_en  = 1'b1;
				state_d = resume_q;
			end
			sha1md_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall && word_q == sha1md_pkg::WORD_LAST) begin
					emit_done = 1'b1;
					state_d   = sha1md_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1md_pkg::ST_IDLE;
			end
		endcase
	end

	// counters and chaining values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bib_q   <= '0;
			count_q <= '0;
			round_q <= '0;
			word_q  <= '0;
			for (int i = 0; i < 5; i++)
				chain_q[i] <= sha1md_pkg::H_INIT[i];
		end else begin
			if (emit_done)
				bib_q <= '0;
			else if (put_en)
				bib_q <= bib_q + 6'd1;
			if (emit_done)
				count_q <= '0;
			else if (count_en)
				count_q <= count_q + 61'd1;
			if (round_run)
				round_q <= (round_q == sha1md_pkg::ROUND_LAST) ? '0 : round_q + 7'd1;
			if (out_valid && !out_stall)
				word_q <= (word_q == sha1md_pkg::WORD_LAST) ? '0 : word_q + 3'd1;
			if (emit_done) begin
				for (int i = 0; i < 5; i++)
					chain_q[i] <= sha1md_pkg::H_INIT[i];
			end else if (add_en) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
		end
	end

	// block window: bytes shift in at the tail, schedule words rotate through
	always_ff @(posedge clk) begin
		if (put_en) begin
			for (int i = 0; i < 15; i++)
				blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
			blk_q[15] <= {blk_q[15][23:0], put_val};
		end else if (round_run) begin
			for (int i = 0; i < 15; i++)
				blk_q[i] <= blk_q[i+1];
			blk_q[15] <= w_cur;
		end
	end

	// working variables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
		end else if (load_round) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (round_run) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

FILE: rtl/sha1md_checker.sv
// ------------------------------------------------------------------------
// sha1md_checker
// port-level checks of the sha-1 digest core, bound to the top level
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic        last_word
);

	// a stalled word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(last_word), "stalled digest word changed")

	// no item is taken while the digest is shown
	`ASSERT_IMPLIES(a_no_in_during_out, clk, arst_n, out_valid, in_stall, "input open during digest output")

	// the five words come without a gap
	`ASSERT_NEXT(a_words_contiguous, clk, arst_n, out_valid && !out_stall && !last_word, out_valid, "gap inside digest output")

	// output ends after the last word
	`ASSERT_NEXT(a_end_after_last, clk, arst_n, out_valid && !out_stall && last_word, !out_valid, "output continued after last word")

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digest_word (digest_word),
	.last_word   (last_word)
);

FILE: tb/sha1_message_digest_core_test.sv
// ------------------------------------------------------------------------
// sha1_message_digest_core_test
// self-checking bench for the streaming sha-1 core: messages go in one byte
// per item, a local sha-1 model predicts the five digest words of each
// message, and every output word is compared with the oldest prediction
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_core_test;

	// sha-1 initial chaining values and round constants
	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [31:0] SHA1_K0 = 32'h5A827999;
	localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;
	localparam logic [7:0]  MSG_PAD = 8'h80;
	localparam logic [5:0]  LEN_FIELD_POS = 6'd56;

	localparam int RANDOM_ITEMS = 85;
	localparam int RANDOM_MSGS_MIN = 10;
	localparam int LONG_HOLD_AFTER = 40;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 400;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic [7:0] data;
		logic       present;
		logic       eom;
		bit         hold_until_drained;
	} msg_item_t;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} digest_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        data_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic        last_word;

	// predictor state
	logic [31:0] hash_state [5];
	logic [31:0] msg_block [16];
	logic [5:0]  block_fill;
	logic [60:0] msg_len;

	msg_item_t   outgoing_items [$];
	digest_out_t digest_words_due [$];

	int          words_predicted = 0;
	int          received_count = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          msgs_hashed = 0;
	int          bytes_hashed = 0;
	int          longest_msg = 0;
	int          rand_items = 0;
	int          rand_msgs = 0;

	// driver variables
	msg_item_t   next_item;
	bit          item_taken;
	bit          tx_calm = 1'b0;
	int          tx_gap = 0;

	// receiver variables
	bit          rx_calm = 1'b0;
	bit          long_hold_done = 1'b0;
	int          rx_wait = 0;
	int          hold_left = 0;
	digest_out_t due_word;

	sha1_message_digest_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.data_present   (data_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_word    (digest_word),
		.last_word      (last_word)
	);

	always #5 clk = ~clk;

	// 80-round compression of the current block into the chaining words
	function automatic void compress_block();
		logic [31:0] sched [16];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		sched = msg_block;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				x = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15]
					^ sched[r & 15];
				sched[r & 15] = {x[30:0], x[31]};
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = SHA1_K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = SHA1_K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = SHA1_K2;
			end else begin
				f = b ^ c ^ d;
				k = SHA1_K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + sched[r & 15];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	// pack one byte big-endian into the block, compressing when full
	function automatic void absorb_byte(input logic [7:0] value);
		int shift;
		shift = (3 - block_fill[1:0]) * 8;
		if (block_fill[1:0] == 2'd0)
			msg_block[block_fill[5:2]] = 32'(value) << shift;
		else
			msg_block[block_fill[5:2]] |= 32'(value) << shift;
		block_fill = block_fill + 6'd1;
		if (block_fill == 6'd0)
			compress_block();
	endfunction

	// work out the digest words caused by one accepted item
	function automatic void hash_item(input logic [7:0] value, input logic present,
			input logic eom);
		logic [63:0] bit_len;
		digest_out_t due;
		if (present) begin
			absorb_byte(value);
			msg_len = msg_len + 61'd1;
			bytes_hashed++;
		end
		if (!eom)
			return;
		if (int'(msg_len) > longest_msg)
			longest_msg = int'(msg_len);
		bit_len = {msg_len, 3'b000};
		absorb_byte(MSG_PAD);
		while (block_fill != LEN_FIELD_POS)
			absorb_byte(8'h00);
		for (int i = 7; i >= 0; i--)
			absorb_byte(bit_len[i * 8 +: 8]);
		for (int i = 0; i < 5; i++) begin
			due.word = hash_state[i];
			due.last = (i == 4);
			digest_words_due.insert(digest_words_due.size(), due);
			words_predicted++;
		end
		hash_state = SHA1_IV;
		block_fill = 6'd0;
		msg_len = 61'd0;
		msgs_hashed++;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] value;
		case ($urandom_range(0, 7))
			0: value = 8'h00;
			1: value = 8'hFF;
			default: value = 8'($urandom);
		endcase
		return value;
	endfunction

	task automatic push_item(input logic [7:0] value, input logic present, input logic eom,
			input bit hold);
		msg_item_t entry;
		entry.data = value;
		entry.present = present;
		entry.eom = eom;
		entry.hold_until_drained = hold;
		outgoing_items.insert(outgoing_items.size(), entry);
	endtask

	// one random message, closed by its last byte or by a separate end item
	task automatic queue_message(input int len, input bit close_alone, input bit hold);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
			push_item(pick_byte(), 1'b1, (i == len - 1) && !close_alone, hold && i == 0);
			rand_items++;
		end
		if (close_alone || len == 0) begin
			push_item(8'($urandom), 1'b0, 1'b1, hold && len == 0);
			rand_items++;
		end
		rand_msgs++;
	endtask

	// stimulus
	initial begin
		int len;
		hash_state = SHA1_IV;
		block_fill = 6'd0;
		msg_len = 61'd0;

		// directed: idle item, empty message, single-byte extremes
		push_item(8'hFF, 1'b0, 1'b0, 1'b0);
		push_item(8'hA5, 1'b0, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b1, 1'b0);
		// short message closed by an end-only item
		push_item(8'h61, 1'b1, 1'b0, 1'b0);
		push_item(8'h62, 1'b1, 1'b0, 1'b0);
		push_item(8'h63, 1'b1, 1'b0, 1'b0);
		push_item(8'h5A, 1'b0, 1'b1, 1'b0);
		// idle item in the middle of a message
		push_item(8'h7F, 1'b1, 1'b0, 1'b0);
		push_item(8'h80, 1'b1, 1'b0, 1'b0);
		push_item(8'h3C, 1'b0, 1'b0, 1'b0);
		push_item(8'h01, 1'b1, 1'b1, 1'b0);
		// empty messages back to back
		push_item(8'h00, 1'b0, 1'b1, 1'b0);
		push_item(8'hFF, 1'b0, 1'b1, 1'b0);

		// random messages, mostly short, some around the block boundaries
		while (rand_items < RANDOM_ITEMS || rand_msgs < RANDOM_MSGS_MIN) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					3: len = 64;
					4: len = 119;
					default: len = 120;
				endcase
			end else begin
				len = $urandom_range(0, 9);
			end
			queue_message(len, $urandom_range(0, 2) == 0,
				rand_msgs == 0 || $urandom_range(0, 5) == 0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all items to go in and all digests to come out
		while (outgoing_items.size() > 0 || in_valid)
			@(negedge clk);
		while (digest_words_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("hashed %0d messages, %0d bytes in all, longest %0d bytes; %0d digest words",
			msgs_hashed, bytes_hashed, longest_msg, received_count);
		$display("incl. empty and one-block/two-block padding, idle items and a long output hold");
		if (mismatches == 0 && digest_words_due.size() == 0)
			$display("sha1_message_digest_core_test passed");
		else
			$display("sha1_message_digest_core_test failed");
		$finish;
	end

	// input driver: random gap before each item, optional wait for drain
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			item_taken = in_valid && !in_stall;
			if (item_taken) begin
				hash_item(data_byte, data_present, end_of_message);
				if ($urandom_range(0, 24) == 0)
					tx_calm = !tx_calm;
				tx_gap = tx_calm ? 0 : $urandom_range(0, 11);
			end
			if (!in_valid || item_taken) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (outgoing_items.size() > 0 &&
						!(outgoing_items[0].hold_until_drained &&
						words_predicted != received_count)) begin
					next_item = outgoing_items.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_item.data;
					data_present <= next_item.present;
					end_of_message <= next_item.eom;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall: random wait per word, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!long_hold_done && received_count >= LONG_HOLD_AFTER) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_done = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if ($urandom_range(0, 24) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !rx_calm && !out_valid && $urandom_range(0, 3) == 0;
			end
		end
	end

	// output monitor: compare each word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			received_count <= 0;
		end else if (out_valid && !out_stall) begin
			received_count <= received_count + 1;
			if (digest_words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected digest word %h last %b", digest_word, last_word);
			end else begin
				due_word = digest_words_due.pop_front();
				if (digest_word !== due_word.word || last_word !== due_word.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("digest word %0d: expected %h last %b, got %h last %b",
							received_count, due_word.word, due_word.last,
							digest_word, last_word);
				end
			end
		end
	end

	// run time limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("sha1_message_digest_core_test failed");
			$finish;
		end
	end

endmodule
